// ===== src/hrct_pkg.sv =====
// ----------------------------------------------------------------------------
// hrct_pkg: shared types and constants for the heart-rate tracker
// Operation codes, queue item and result layouts, register indexes and
// register reset values.
// ----------------------------------------------------------------------------
package hrct_pkg;

  // Fixed field widths
  localparam int RATE_FIELD_W = 12;
  localparam int COUNT_W      = 4;
  localparam int CFG_IDX_W    = 3;

  // Operation selected by the front end
  typedef enum logic [1:0] {
    OP_APPLY = 2'd0,
    OP_CLEAR = 2'd1,
    OP_HOLD  = 2'd2
  } op_t;

  // Item passed from front to back
  typedef struct packed {
    op_t                     op;
    logic [RATE_FIELD_W-1:0] est;
  } item_t;

  // Result item
  typedef struct packed {
    logic [RATE_FIELD_W-1:0] heart_rate;
    logic                    rate_locked;
    logic [COUNT_W-1:0]      candidate_count;
  } result_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_MATCH_WINDOW = 3'd0,
    REG_STABLE_BAND          = 3'd1,
    REG_MODERATE_BAND        = 3'd2,
    REG_CONFIRM_MATCH_WINDOW = 3'd3,
    REG_STABLE_STEP          = 3'd4,
    REG_MODERATE_STEP        = 3'd5,
    REG_CONFIRMED_STEP       = 3'd6,
    REG_CONFIRMATIONS_NEEDED = 3'd7
  } reg_idx_t;

  // Register reset values, Q8.4 bpm
  localparam logic [RATE_FIELD_W-1:0] INITIAL_MATCH_WINDOW_RST = 12'd96;
  localparam logic [RATE_FIELD_W-1:0] STABLE_BAND_RST          = 12'd48;
  localparam logic [RATE_FIELD_W-1:0] MODERATE_BAND_RST        = 12'd128;
  localparam logic [RATE_FIELD_W-1:0] CONFIRM_MATCH_WINDOW_RST = 12'd64;
  localparam logic [RATE_FIELD_W-1:0] STABLE_STEP_RST          = 12'd32;
  localparam logic [RATE_FIELD_W-1:0] MODERATE_STEP_RST        = 12'd56;
  localparam logic [RATE_FIELD_W-1:0] CONFIRMED_STEP_RST       = 12'd80;
  localparam logic [COUNT_W-1:0]      CONFIRMATIONS_NEEDED_RST = 4'd2;

  // Saturation value of the confirmation counter
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

endpackage

// ===== src/heart_rate_confirm_slew_tracker.sv =====
// ----------------------------------------------------------------------------
// heart_rate_confirm_slew_tracker: confirmed, slew-limited heart-rate tracker
// Front end classifies estimates into a two-entry work queue; the back end
// updates the tracked rate and reports it through a two-entry result queue.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction is written into the work queue; the back end
// then runs the update and writes the result queue once that queue has room,
// and the result shows on the result ports.
// Throughput: one transaction per cycle while the result queue is not full;
// the back end updates its state for each item it takes.
// Reset: rst clears both queues and the tracking state and loads the
// configuration registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module heart_rate_confirm_slew_tracker
  import hrct_pkg::*;
#(
  parameter int INITIAL_CONFIRMATIONS = 2,
  parameter int RATE_WIDTH            = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  // Input queue side
  input  logic                    push,
  output logic                    full,
  input  logic                    cmd,
  input  logic [RATE_FIELD_W-1:0] estimate_rate,
  // Result queue side
  output logic                    empty,
  input  logic                    pop,
  output logic [RATE_FIELD_W-1:0] heart_rate,
  output logic                    rate_locked,
  output logic [COUNT_W-1:0]      candidate_count,
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [RATE_FIELD_W-1:0] cfg_data
);

  // Rates never exceed the estimate field width
  localparam int RateW = (RATE_WIDTH < RATE_FIELD_W) ? RATE_WIDTH : RATE_FIELD_W;

  logic    q_wr_en;
  logic    q_full;
  logic    q_empty;
  logic    q_rd_en;
  item_t   q_wr_item;
  item_t   q_rd_item;
  result_t result;

  hrct_front #(
    .RATE_W(RateW)
  ) u_front (
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .estimate_rate (estimate_rate),
    .q_wr_en       (q_wr_en),
    .q_item        (q_wr_item),
    .q_full        (q_full)
  );

  hrct_queue #(
    .W($bits(item_t))
  ) u_work_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_item),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_item),
    .empty   (q_empty)
  );

  hrct_back #(
    .RATE_W                (RateW),
    .INITIAL_CONFIRMATIONS (INITIAL_CONFIRMATIONS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_rd_en   (q_rd_en),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign heart_rate      = result.heart_rate;
  assign rate_locked     = result.rate_locked;
  assign candidate_count = result.candidate_count;

endmodule

// ===== src/hrct_queue.sv =====
// ----------------------------------------------------------------------------
// hrct_queue: two-entry first-in first-out queue
// Decouples producer and consumer; a read and a write may share a cycle.
// ----------------------------------------------------------------------------
module hrct_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store incoming entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/hrct_front.sv =====
// ----------------------------------------------------------------------------
// hrct_front: input acceptance and classification
// Masks the estimate to the rate width and tags each transaction as
// apply, clear or hold before it enters the work queue.
// ----------------------------------------------------------------------------
module hrct_front
  import hrct_pkg::*;
#(
  parameter int RATE_W = 12
) (
  input  logic                    push,
  output logic                    full,
  input  logic                    cmd,
  input  logic [RATE_FIELD_W-1:0] estimate_rate,
  output logic                    q_wr_en,
  output item_t                   q_item,
  input  logic                    q_full
);

  logic [RATE_W-1:0] est_masked;

  assign full       = q_full;
  assign q_wr_en    = push && !q_full;
  assign est_masked = estimate_rate[RATE_W-1:0];

  // Classify the transaction
  always_comb begin
    q_item.est = RATE_FIELD_W'(est_masked);
    if (cmd) begin
      q_item.op = OP_CLEAR;
    end else if (est_masked == '0) begin
      q_item.op = OP_HOLD;
    end else begin
      q_item.op = OP_APPLY;
    end
  end

endmodule

// ===== src/hrct_back.sv =====
// ----------------------------------------------------------------------------
// hrct_back: tracking state update and result queue
// Holds the configuration registers and tracker state; applies one queued item per
// cycle while the output queue has room and pushes each report into that queue.
// ----------------------------------------------------------------------------
module hrct_back
  import hrct_pkg::*;
#(
  parameter int RATE_W                = 12,
  parameter int INITIAL_CONFIRMATIONS = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [RATE_FIELD_W-1:0] cfg_data,
  // Work queue side
  input  logic                    q_empty,
  input  item_t                   q_item,
  output logic                    q_rd_en,
  // Result side
  output logic                    empty,
  input  logic                    pop,
  output result_t                 result
);

  // Configuration registers
  logic [RATE_FIELD_W-1:0] initial_match_window;
  logic [RATE_FIELD_W-1:0] stable_band;
  logic [RATE_FIELD_W-1:0] moderate_band;
  logic [RATE_FIELD_W-1:0] confirm_match_window;
  logic [RATE_FIELD_W-1:0] stable_step;
  logic [RATE_FIELD_W-1:0] moderate_step;
  logic [RATE_FIELD_W-1:0] confirmed_step;
  logic [COUNT_W-1:0]      confirmations_needed;

  // Tracker state
  logic [RATE_W-1:0]  tracked_rate;
  logic [RATE_W-1:0]  tracked_rate_next;
  logic [RATE_W-1:0]  candidate_rate;
  logic [RATE_W-1:0]  candidate_rate_next;
  logic [COUNT_W-1:0] confirm_count;
  logic [COUNT_W-1:0] confirm_count_next;

  logic               take;
  logic               out_full;
  logic [RATE_W-1:0]  est;
  logic [RATE_W:0]    pair_sum;
  logic [RATE_W-1:0]  avg;
  logic [RATE_W-1:0]  dev;
  logic [RATE_W-1:0]  cand_dist;
  logic [COUNT_W-1:0] count_bumped;
  result_t            res_next;

  function automatic logic [RATE_W-1:0] abs_diff(input logic [RATE_W-1:0] a,
                                                 input logic [RATE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Move cur toward target by at most step, never past it
  function automatic logic [RATE_W-1:0] slew_toward(input logic [RATE_W-1:0] cur,
                                                    input logic [RATE_W-1:0] target,
                                                    input logic [RATE_FIELD_W-1:0] step);
    logic [RATE_W-1:0] d;
    d = abs_diff(cur, target);
    if (RATE_FIELD_W'(d) > step) begin
      if (target > cur) begin
        return cur + RATE_W'(step);
      end else begin
        return cur - RATE_W'(step);
      end
    end
    return target;
  endfunction

  assign cfg_ready    = 1'b1;
  assign take         = !q_empty && !out_full;
  assign q_rd_en      = take;
  assign est          = q_item.est[RATE_W-1:0];
  assign pair_sum     = {1'b0, candidate_rate} + {1'b0, est};
  assign avg          = pair_sum[RATE_W:1];
  assign dev          = abs_diff(est, tracked_rate);
  assign cand_dist    = abs_diff(est, candidate_rate);
  assign count_bumped = (confirm_count == COUNT_MAX) ? COUNT_MAX : confirm_count + 4'd1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_match_window <= INITIAL_MATCH_WINDOW_RST;
      stable_band          <= STABLE_BAND_RST;
      moderate_band        <= MODERATE_BAND_RST;
      confirm_match_window <= CONFIRM_MATCH_WINDOW_RST;
      stable_step          <= STABLE_STEP_RST;
      moderate_step        <= MODERATE_STEP_RST;
      confirmed_step       <= CONFIRMED_STEP_RST;
      confirmations_needed <= CONFIRMATIONS_NEEDED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_INITIAL_MATCH_WINDOW: initial_match_window <= cfg_data;
        REG_STABLE_BAND:          stable_band          <= cfg_data;
        REG_MODERATE_BAND:        moderate_band        <= cfg_data;
        REG_CONFIRM_MATCH_WINDOW: confirm_match_window <= cfg_data;
        REG_STABLE_STEP:          stable_step          <= cfg_data;
        REG_MODERATE_STEP:        moderate_step        <= cfg_data;
        REG_CONFIRMED_STEP:       confirmed_step       <= cfg_data;
        REG_CONFIRMATIONS_NEEDED: confirmations_needed <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Compute next tracker state for the item at the queue head
  always_comb begin
    tracked_rate_next   = tracked_rate;
    candidate_rate_next = candidate_rate;
    confirm_count_next  = confirm_count;
    case (q_item.op)
      OP_CLEAR: begin
        tracked_rate_next   = '0;
        candidate_rate_next = '0;
        confirm_count_next  = '0;
      end
      OP_HOLD: begin
      end
      OP_APPLY: begin
        if (tracked_rate == '0) begin
          // Acquire: pair up nearby estimates before committing
          if (confirm_count == '0 || RATE_FIELD_W'(cand_dist) > initial_match_window) begin
            candidate_rate_next = est;
            confirm_count_next  = 4'd1;
          end else if (count_bumped < COUNT_W'(INITIAL_CONFIRMATIONS)) begin
            candidate_rate_next = avg;
            confirm_count_next  = count_bumped;
          end else begin
            tracked_rate_next   = avg;
            candidate_rate_next = '0;
            confirm_count_next  = '0;
          end
        end else if (RATE_FIELD_W'(dev) <= stable_band) begin
          tracked_rate_next   = slew_toward(tracked_rate, est, stable_step);
          candidate_rate_next = '0;
          confirm_count_next  = '0;
        end else if (RATE_FIELD_W'(dev) <= moderate_band) begin
          tracked_rate_next   = slew_toward(tracked_rate, est, moderate_step);
          candidate_rate_next = '0;
          confirm_count_next  = '0;
        end else if (confirm_count == '0 ||
                     RATE_FIELD_W'(cand_dist) > confirm_match_window) begin
          // Start a new jump candidate
          candidate_rate_next = est;
          confirm_count_next  = 4'd1;
        end else if (count_bumped < confirmations_needed) begin
          confirm_count_next = count_bumped;
        end else begin
          tracked_rate_next   = slew_toward(tracked_rate, candidate_rate, confirmed_step);
          candidate_rate_next = '0;
          confirm_count_next  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_rate   <= '0;
      candidate_rate <= '0;
      confirm_count  <= '0;
    end else if (take) begin
      tracked_rate   <= tracked_rate_next;
      candidate_rate <= candidate_rate_next;
      confirm_count  <= confirm_count_next;
    end
  end

  // Build the report from the updated state
  always_comb begin
    res_next.heart_rate      = RATE_FIELD_W'(tracked_rate_next);
    res_next.rate_locked     = (tracked_rate_next != '0);
    res_next.candidate_count = confirm_count_next;
  end

  hrct_queue #(
    .W($bits(result_t))
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (res_next),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

  // A clear transaction leaves all tracking state at zero
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (take && q_item.op == OP_CLEAR) |=>
      (tracked_rate == '0 && candidate_rate == '0 && confirm_count == '0))
    else $error("tracker state not cleared");

  // A hold transaction leaves state untouched
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    (take && q_item.op == OP_HOLD) |=>
      ($stable(tracked_rate) && $stable(candidate_rate) && $stable(confirm_count)))
    else $error("tracker state changed on zero estimate");

  // Once locked, only a clear can unlock
  a_lock_kept: assert property (@(posedge clk) disable iff (rst)
    (take && tracked_rate != '0 && q_item.op != OP_CLEAR) |=> (tracked_rate != '0))
    else $error("tracked rate dropped to zero without clear");

  // Tracked rate and confirmation count only change when an item is taken
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !take |=> ($stable(tracked_rate) && $stable(confirm_count)))
    else $error("tracker state changed without a transaction");

endmodule
